/* src/dqap_pkg.sv */
// Shared constants, types and helpers for the dotted-quad address parser.
`default_nettype none

package dqap_pkg;

    localparam int CHAR_W = 8;
    localparam int ADDR_W = 32;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // character codes
    localparam char_t CH_NUL   = 8'h00;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_DOT   = 8'h2E;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;

    // largest part value that fits a single leading byte
    localparam addr_t BYTE_MAX = 32'h0000_00FF;

    // bound on the last part, by number of parts already completed
    function automatic addr_t last_max(input logic [1:0] parts);
        addr_t bound;
        unique case (parts)
            2'd0:    bound = 32'hFFFF_FFFF;
            2'd1:    bound = 32'h00FF_FFFF;
            2'd2:    bound = 32'h0000_FFFF;
            default: bound = 32'h0000_00FF;
        endcase
        return bound;
    endfunction

    // whitespace: space, tab, LF, VT, FF, CR
    function automatic logic is_space(input char_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

/* src/dqap_if.sv */
// Valid/ready channel interfaces for characters in and parse results out.
`default_nettype none

interface dqap_char_if;
    logic           valid;
    logic           ready;
    dqap_pkg::char_t character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);
endinterface

interface dqap_res_if;
    logic            valid;
    logic            ready;
    logic            valid_res;
    dqap_pkg::addr_t address;

    modport source (output valid, output valid_res, output address, input ready);
    modport sink   (input valid, input valid_res, input address, output ready);
endinterface

`default_nettype wire

/* src/dotted_quad_address_parser_unit.sv */
// Top level: streaming dotted-decimal IPv4 address parser.
`default_nettype none

// Takes one character word per cycle on chars and gives one result word on
// results for every NUL character: valid_res and the 32-bit address, first
// part in the most significant byte (address 0 when invalid). A character is
// held in an input register and the parse state is updated from it; the
// per-character accumulator update (part * 10 + digit, a shift-and-add)
// sets the one-word-per-cycle rate. A result waits in a result register,
// loaded as its NUL is taken, so characters keep flowing; only a NUL
// meeting a full, stalled result register holds the input. Up to four
// decimal parts; all but the last are limited to 255, the last fills the
// remaining bytes. First whitespace ends parsing.
module dotted_quad_address_parser_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    dqap_char_if.sink       chars,
    dqap_res_if.source      results
);

    typedef enum logic [1:0] {
        PH_START,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    // input register
    logic             in_vld_reg;
    dqap_pkg::char_t  char_reg;

    // parse state
    phase_t           phase_reg,     phase_next;
    dqap_pkg::addr_t  part_reg,      part_next;
    logic             part_ovf_reg,  part_ovf_next;
    logic [1:0]       parts_reg,     parts_next;
    logic [23:0]      leading_reg,   leading_next;
    logic             failed_reg,    failed_next;

    // result register
    logic             res_vld_reg;
    logic             res_ok_reg,    res_ok_next;
    dqap_pkg::addr_t  res_addr_reg,  res_addr_next;

    logic             is_nul;
    logic             is_digit;
    logic             out_free;
    logic             advance;
    logic [35:0]      acc_wide;
    logic [3:0]       digit;
    logic             last_bad;
    logic             fail_at_nul;
    dqap_pkg::addr_t  joined_addr;

    // handshake
    assign is_nul   = (char_reg == dqap_pkg::CH_NUL);
    assign out_free = !res_vld_reg || results.ready;
    assign advance  = in_vld_reg && (!is_nul || out_free);
    assign chars.ready = !in_vld_reg || advance;

    assign results.valid     = res_vld_reg;
    assign results.valid_res = res_ok_reg;
    assign results.address   = res_addr_reg;

    // accumulator: part * 10 + digit, 36 bits wide to see overflow
    assign is_digit = (char_reg >= dqap_pkg::CH_ZERO) && (char_reg <= dqap_pkg::CH_NINE);
    assign digit    = 4'(char_reg - dqap_pkg::CH_ZERO);
    assign acc_wide = {1'b0, part_reg, 3'b000} + {3'b000, part_reg, 1'b0} + {32'd0, digit};

    // bound check on the last part
    assign last_bad = part_ovf_reg || (part_reg > dqap_pkg::last_max(parts_reg));
    assign fail_at_nul = failed_reg || (phase_reg == PH_START)
                         || ((phase_reg == PH_DIGITS) && last_bad);

    // leading bytes placed above the last part
    always_comb
    begin
        unique case (parts_reg)
            2'd0:    joined_addr = part_reg;
            2'd1:    joined_addr = {leading_reg[7:0], 24'd0} | part_reg;
            2'd2:    joined_addr = {leading_reg[15:0], 16'd0} | part_reg;
            default: joined_addr = {leading_reg, 8'd0} | part_reg;
        endcase
    end

    // next parse state and result
    always_comb
    begin
        phase_next    = phase_reg;
        part_next     = part_reg;
        part_ovf_next = part_ovf_reg;
        parts_next    = parts_reg;
        leading_next  = leading_reg;
        failed_next   = failed_reg;
        res_ok_next   = !fail_at_nul;
        res_addr_next = fail_at_nul ? '0 : joined_addr;

        if (is_nul)
        begin
            phase_next    = PH_START;
            part_next     = '0;
            part_ovf_next = 1'b0;
            parts_next    = '0;
            leading_next  = '0;
            failed_next   = 1'b0;
        end
        else if (failed_reg || (phase_reg == PH_DONE))
        begin
            // ignore until NUL
        end
        else if (is_digit)
        begin
            part_next     = acc_wide[31:0];
            part_ovf_next = part_ovf_reg || (acc_wide[35:32] != 4'd0);
            phase_next    = PH_DIGITS;
        end
        else if (phase_reg == PH_START)
        begin
            failed_next = 1'b1;
        end
        else if (char_reg == dqap_pkg::CH_DOT)
        begin
            if ((parts_reg == 2'd3) || part_ovf_reg || (part_reg > dqap_pkg::BYTE_MAX))
            begin
                failed_next = 1'b1;
            end
            else
            begin
                leading_next  = {leading_reg[15:0], part_reg[7:0]};
                parts_next    = parts_reg + 2'd1;
                part_next     = '0;
                part_ovf_next = 1'b0;
                phase_next    = PH_START;
            end
        end
        else if (dqap_pkg::is_space(char_reg))
        begin
            failed_next = last_bad;
            phase_next  = PH_DONE;
        end
        else
        begin
            failed_next = 1'b1;
        end
    end

    // state, input and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            res_vld_reg  <= 1'b0;
            phase_reg    <= PH_START;
            part_reg     <= '0;
            part_ovf_reg <= 1'b0;
            parts_reg    <= '0;
            leading_reg  <= '0;
            failed_reg   <= 1'b0;
        end
        else
        begin
            if (chars.ready)
            begin
                in_vld_reg <= chars.valid;
            end

            if (advance)
            begin
                phase_reg    <= phase_next;
                part_reg     <= part_next;
                part_ovf_reg <= part_ovf_next;
                parts_reg    <= parts_next;
                leading_reg  <= leading_next;
                failed_reg   <= failed_next;
            end

            if (advance && is_nul)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            char_reg <= chars.character;
        end
        if (advance && is_nul)
        begin
            res_ok_reg   <= res_ok_next;
            res_addr_reg <= res_addr_next;
        end
    end

endmodule

`default_nettype wire

/* test/tb_dotted_quad_address_parser_unit.sv */
// Testbench for the dotted-quad address parser: random and directed strings, scoreboard check.
`timescale 1ns / 100ps

module tb_dotted_quad_address_parser_unit;

    localparam int STALL_LIMIT  = 2000;   // cycles with no word moving on either side
    localparam int PHASE_CHARS  = 340;    // random characters per idling phase
    localparam int SETTLE_TICKS = 8;      // slack after the last result is in

    typedef enum logic [1:0] {AWAIT_DIGIT, IN_DIGITS, SKIP_TAIL} scan_phase_t;

    typedef struct packed {
        logic            ok;
        dqap_pkg::addr_t addr;
    } parse_result_t;

    typedef struct {
        dqap_pkg::char_t ch;
        bit              drain;   // hold off until every result due has arrived
        int unsigned     mode;    // idling profile while this word is in flight
    } char_word_t;

    // idling profiles: sender gaps and receiver stalls, percent of cycles
    int unsigned send_gap_pct [3] = '{6, 51, 0};
    int unsigned recv_stall_pct [3] = '{51, 6, 0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic            chr_valid = 1'b0;
    dqap_pkg::char_t chr_data = dqap_pkg::CH_NUL;
    logic            res_ready = 1'b0;

    char_word_t      pending_q[$];
    dqap_pkg::char_t line_q[$];
    parse_result_t   address_due_q[$];
    parse_result_t   due;

    int unsigned fill_mode = 0;
    int unsigned tx_mode = 0;
    int          mismatches = 0;
    int          idle_ticks = 0;

    // parser state as predicted by the testbench
    scan_phase_t     scan_phase = AWAIT_DIGIT;
    dqap_pkg::addr_t part_val = '0;
    logic            part_ovf = 1'b0;
    logic [1:0]      parts_done = '0;
    logic [23:0]     lead_bytes = '0;
    logic            str_bad = 1'b0;

    dqap_char_if chars ();
    dqap_res_if  results ();

    assign chars.valid     = chr_valid;
    assign chars.character = chr_data;
    assign results.ready   = res_ready;

    dotted_quad_address_parser_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars),
        .results (results)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // last part against the bound left by the parts before it
    function automatic bit last_part_out_of_range();
        dqap_pkg::addr_t lim;
        case (parts_done)
            2'd0:    lim = 32'hFFFF_FFFF;
            2'd1:    lim = 32'h00FF_FFFF;
            2'd2:    lim = 32'h0000_FFFF;
            default: lim = 32'h0000_00FF;
        endcase
        return part_ovf || (part_val > lim);
    endfunction

    // advance the predicted parse by one character; a NUL yields an address
    function automatic void parse_char(input dqap_pkg::char_t c);
        logic [63:0]     acc;
        logic [55:0]     wide;
        dqap_pkg::addr_t addr;
        if (c == dqap_pkg::CH_NUL)
        begin
            if (!str_bad)
            begin
                if (scan_phase == AWAIT_DIGIT)
                    str_bad = 1'b1;
                else if (scan_phase == IN_DIGITS && last_part_out_of_range())
                    str_bad = 1'b1;
            end
            addr = '0;
            if (!str_bad)
            begin
                // earlier parts above the last one; shift of 32 clears them when none
                wide = {32'b0, lead_bytes} << (32 - 8 * parts_done);
                addr = wide[31:0] | part_val;
            end
            address_due_q.push_back('{ok: !str_bad, addr: addr});
            scan_phase = AWAIT_DIGIT;
            part_val   = '0;
            part_ovf   = 1'b0;
            parts_done = '0;
            lead_bytes = '0;
            str_bad    = 1'b0;
            return;
        end
        if (str_bad || scan_phase == SKIP_TAIL)
            return;
        if (c >= dqap_pkg::CH_ZERO && c <= dqap_pkg::CH_NINE)
        begin
            acc = {32'b0, part_val} * 64'd10 + {56'b0, c - dqap_pkg::CH_ZERO};
            if (acc[63:32] != '0)
                part_ovf = 1'b1;
            part_val   = acc[31:0];
            scan_phase = IN_DIGITS;
        end
        else if (scan_phase == AWAIT_DIGIT)
            str_bad = 1'b1;
        else if (c == dqap_pkg::CH_DOT)
        begin
            if (parts_done == 2'd3 || part_ovf || part_val > dqap_pkg::BYTE_MAX)
                str_bad = 1'b1;
            else
            begin
                lead_bytes = {lead_bytes[15:0], part_val[7:0]};
                parts_done++;
                part_val   = '0;
                part_ovf   = 1'b0;
                scan_phase = AWAIT_DIGIT;
            end
        end
        else if (c == dqap_pkg::CH_SPACE
                 || (c >= dqap_pkg::CH_TAB && c <= dqap_pkg::CH_CR))
        begin
            if (last_part_out_of_range())
                str_bad = 1'b1;
            scan_phase = SKIP_TAIL;
        end
        else
            str_bad = 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t ns: result mismatch: %s", $time, what);
    endtask

    // ---- stimulus building ----

    task automatic add_text(input string s);
        foreach (s[i])
            line_q.push_back(dqap_pkg::char_t'(s[i]));
    endtask

    // move the line under construction into the send queue, closed by a NUL
    task automatic flush_line(input bit drain);
        foreach (line_q[i])
            pending_q.push_back('{ch: line_q[i], drain: drain && i == 0, mode: fill_mode});
        pending_q.push_back('{ch: dqap_pkg::CH_NUL, drain: drain && line_q.size() == 0,
                              mode: fill_mode});
        line_q.delete();
    endtask

    // one part, weighted towards the edges of its bound
    task automatic add_part(input longint unsigned bound);
        case ($urandom_range(0, 11))
            0:       add_text("0");
            1:       add_text($sformatf("%0d", bound));
            2:       add_text($sformatf("%0d", bound + 1));
            3:       add_text({"00", $sformatf("%0d", $urandom_range(32'(bound), 0))});
            4:
            begin
                // well past 32 bits
                add_text($sformatf("%0d", $urandom_range(9, 1)));
                repeat ($urandom_range(12, 10))
                    add_text($sformatf("%0d", $urandom_range(9, 0)));
            end
            5, 6:    add_text($sformatf("%0d", $urandom_range(9, 0)));
            default: add_text($sformatf("%0d", $urandom_range(32'(bound), 0)));
        endcase
    endtask

    // one to four parts, sometimes ended by whitespace and a junk tail
    task automatic build_address();
        int n_parts;
        int pick;
        n_parts = $urandom_range(4, 1);
        for (int i = 0; i < n_parts - 1; i++)
        begin
            add_part(255);
            line_q.push_back(dqap_pkg::CH_DOT);
        end
        case (n_parts)
            1:       add_part(64'hFFFF_FFFF);
            2:       add_part(64'h00FF_FFFF);
            3:       add_part(64'h0000_FFFF);
            default: add_part(64'h0000_00FF);
        endcase
        if ($urandom_range(4, 0) == 0)
        begin
            pick = $urandom_range(6, 0);
            line_q.push_back(pick == 6 ? dqap_pkg::CH_SPACE
                                       : dqap_pkg::char_t'(dqap_pkg::CH_TAB + pick));
            repeat ($urandom_range(4, 0))
                line_q.push_back(dqap_pkg::char_t'($urandom_range(255, 1)));
        end
    endtask

    // ---- driver: character words from the pending queue ----
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chr_valid <= 1'b0;
            chr_data  <= dqap_pkg::CH_NUL;
        end
        else
        begin
            if (chr_valid && chars.ready)
                parse_char(chr_data);
            if (!chr_valid || chars.ready)
            begin
                if (pending_q.size() != 0
                    && $urandom_range(99, 0) >= send_gap_pct[pending_q[0].mode]
                    && (!pending_q[0].drain || address_due_q.size() == 0))
                begin
                    chr_valid <= 1'b1;
                    chr_data  <= pending_q[0].ch;
                    tx_mode   <= pending_q[0].mode;
                    void'(pending_q.pop_front());
                end
                else
                    chr_valid <= 1'b0;
            end
        end
    end

    // ---- monitor: result words against the oldest prediction ----
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            if (results.valid && res_ready)
            begin
                if (address_due_q.size() == 0)
                    flag_mismatch($sformatf("unexpected word valid_res %0b address %h",
                                            results.valid_res, results.address));
                else
                begin
                    due = address_due_q.pop_front();
                    if (results.valid_res !== due.ok || results.address !== due.addr)
                        flag_mismatch($sformatf("valid_res %0b address %h, wanted %0b %h",
                                                results.valid_res, results.address,
                                                due.ok, due.addr));
                end
            end
            res_ready <= ($urandom_range(99, 0) >= recv_stall_pct[tx_mode]);
        end
    end

    // ---- watchdog: too long with nothing moving ----
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((chr_valid && chars.ready) || (results.valid && res_ready))
                idle_ticks <= 0;
            else
            begin
                idle_ticks <= idle_ticks + 1;
                if (idle_ticks >= STALL_LIMIT)
                begin
                    $display("SCOREBOARD MISMATCH");
                    $finish;
                end
            end
        end
    end

    // ---- sequence: fill the queue, release reset, wait for the scoreboard ----
    initial
    begin
        int  phase_start;
        bit  first;
        int  pick;
        int  idx;

        // directed strings: bounds, empty parts, bad characters, tails
        fill_mode = 0;
        flush_line(1'b0);
        add_text("0");                      flush_line(1'b0);
        add_text("4294967295");             flush_line(1'b0);
        add_text("4294967296");             flush_line(1'b0);
        add_text("12345678901");            flush_line(1'b0);
        add_text("255.255.255.255");        flush_line(1'b0);
        add_text("256.1");                  flush_line(1'b0);
        add_text("1.16777215");             flush_line(1'b0);
        add_text("1.16777216");             flush_line(1'b0);
        add_text("10.2.65535");             flush_line(1'b0);
        add_text("10.2.65536");             flush_line(1'b0);
        add_text("192.168.1.255");          flush_line(1'b0);
        add_text("192.168.1.256");          flush_line(1'b0);
        add_text(".1");                     flush_line(1'b0);
        add_text("1.");                     flush_line(1'b0);
        add_text("1..2");                   flush_line(1'b0);
        add_text("1.2.3.4.5");              flush_line(1'b0);
        add_text("127.0.0.1 x.y");          flush_line(1'b0);
        add_text(" 1");                     flush_line(1'b0);
        add_text("1a2");                    flush_line(1'b0);
        add_text("x1.2.3.4");               flush_line(1'b0);
        add_text("00000000000000000001");   flush_line(1'b0);
        add_text("9");
        line_q.push_back(8'h80);
        add_text("1");
        flush_line(1'b0);
        add_text("1.2.3");
        line_q.push_back(dqap_pkg::CH_CR);
        line_q.push_back(dqap_pkg::CH_TAB);
        line_q.push_back(8'hFF);
        add_text("abc");
        flush_line(1'b0);
        add_text("0.0.0.0");
        line_q.push_back(dqap_pkg::char_t'(dqap_pkg::CH_TAB + 1));
        flush_line(1'b0);

        // random strings, one idling profile per phase
        for (int m = 0; m < 3; m++)
        begin
            fill_mode   = m;
            phase_start = pending_q.size();
            first       = 1'b1;
            while (pending_q.size() - phase_start < PHASE_CHARS)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                    build_address();
                else if (pick < 85)
                begin
                    // generated address with one or two corruptions
                    build_address();
                    repeat ($urandom_range(2, 1))
                    begin
                        idx = $urandom_range(line_q.size() - 1, 0);
                        case ($urandom_range(2, 0))
                            0: line_q[idx] = dqap_pkg::char_t'($urandom_range(255, 1));
                            1: line_q.insert(idx, dqap_pkg::CH_DOT);
                            default:
                                if (line_q.size() > 1)
                                    line_q.delete(idx);
                        endcase
                    end
                end
                else
                    repeat ($urandom_range(8, 0))
                        line_q.push_back(dqap_pkg::char_t'($urandom_range(255, 1)));
                flush_line(first || $urandom_range(39, 0) == 0);
                first = 1'b0;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || chr_valid)
            @(posedge clk);
        while (address_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatches == 0 && address_due_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
